// ===== rtl/core/sal_pkg.sv =====
// Shared constants and types for the suffix array / LCP engine.
package sal_pkg;

    localparam int MaxLen    = 1024;
    localparam int LogLevels = 11;
    localparam int Dw        = 11;
    localparam int PosAw     = 10;
    localparam int CntDepth  = 2048;
    localparam int MtDepth   = LogLevels * MaxLen;
    localparam int LvlW      = 4;

    typedef logic [Dw-1:0] word_t;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_RANK = 2'd1,
        MODE_LCP  = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

endpackage

// ===== rtl/core/sal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sal_ram #(
    parameter int Width = 11,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/suffix_array_lcp_engine_core.sv =====
// Suffix array builder and LCP query engine, top level.
// Load: one beat per cycle. Rank query: reads suffix array and height at position_a.
// LCP query: settled at once or via both ranks and two sparse-table reads, plus any wait
// for the result register to drain. Build after the last symbol: counting sorts, doubling
// rounds, a Kasai height pass and the sparse-table levels; no beat is taken until it ends.
// Reset clears control, length and built flag; memories are not cleared and need no pass.
module suffix_array_lcp_engine_core
    import sal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [10:0] symbol,
    input  logic        last_symbol,
    input  logic [10:0] position_a,
    input  logic [10:0] position_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] suffix_start,
    output logic [10:0] height,
    output logic [10:0] common_length,
    output logic        out_of_range
);

    typedef enum logic [5:0] {
        S_IDLE, S_B0_RD, S_B0_WR,
        S_C1, S_C2_A, S_C2_B, S_C2_C, S_C3_A, S_C3_B,
        S_C4_A, S_C4_B, S_C4_C, S_C4_D,
        S_D1, S_D2_A, S_D2_B, S_D3_A, S_D3_B,
        S_E0, S_E1, S_E2, S_E3, S_F_A, S_F_B,
        S_K0, S_K1, S_K2, S_K3, S_K4, S_K5,
        S_L0_A, S_L0_B, S_M_CHK, S_M0, S_M1, S_M2,
        S_QR, S_QA, S_QB, S_QC, S_QD, S_QE, S_OUT
    } state_t;

    localparam int CntAw = $clog2(CntDepth);
    localparam int MtAw  = $clog2(MtDepth);

    state_t          state_reg;
    word_t           len_reg;
    logic            built_reg;
    logic [11:0]     idx_reg;
    logic [11:0]     p_reg;
    logic [11:0]     k_reg;
    word_t           keymax_reg;
    word_t           run_reg;
    word_t           key_reg;
    word_t           pos_reg;
    word_t           prev1_reg;
    word_t           prev2_reg;
    logic            prevout_reg;
    word_t           cur1_reg;
    word_t           h_reg;
    word_t           r_reg;
    word_t           j_reg;
    word_t           syma_reg;
    word_t           minv_reg;
    logic [LvlW-1:0] lvl_reg;
    logic            first_sort_reg;
    word_t           qa_reg;
    word_t           qb_reg;
    word_t           res_start_reg;
    word_t           res_height_reg;
    word_t           res_common_reg;
    logic            res_oor_reg;
    logic            out_valid_reg;
    word_t           start_reg;
    word_t           height_reg;
    word_t           common_reg;
    logic            oor_reg;

    logic             sym_we, sa_we, rk_we, sk_we, ht_we, cnt_we, mt_we;
    logic [PosAw-1:0] sym_waddr, sa_waddr, rk_waddr, sk_waddr, ht_waddr;
    logic [PosAw-1:0] sym_raddr, sa_raddr, rk_raddr, sk_raddr, ht_raddr;
    word_t            sym_wdata, sa_wdata, rk_wdata, sk_wdata, ht_wdata, cnt_wdata, mt_wdata;
    word_t            sym_q, sa_q, rk_q, sk_q, ht_q, cnt_q, mt_q;
    logic [CntAw-1:0] cnt_waddr, cnt_raddr;
    logic [MtAw-1:0]  mt_waddr, mt_raddr;

    logic            accept;
    word_t           load_len;
    logic            load_room;
    word_t           new_len;
    logic [11:0]     n12;
    logic [PosAw-1:0] idx_a;
    logic [11:0]     apk;
    logic            a_out;
    logic            same;
    logic [11:0]     pnew;
    logic [11:0]     ih;
    logic [11:0]     jh;
    logic            scan_ok;
    logic [11:0]     span;
    logic [11:0]     half;
    word_t           q_min;
    word_t           q_max;
    word_t           qlen;
    logic [LvlW-1:0] qlvl;
    logic [11:0]     qd_pos;
    logic            pa_bad;
    logic            pb_bad;

    function automatic logic [LvlW-1:0] floor_lvl(input word_t v);
        logic [LvlW-1:0] l;
        l = '0;
        for (int s = 1; s < LogLevels; s++)
        begin
            if ((v >> s) != '0)
            begin
                l = LvlW'(s);
            end
        end
        return l;
    endfunction

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign load_len  = built_reg ? '0 : len_reg;
    assign load_room = (load_len < Dw'(MaxLen));
    assign new_len   = load_room ? load_len + 1'b1 : load_len;
    assign n12       = {1'b0, len_reg};
    assign idx_a     = idx_reg[PosAw-1:0];
    assign apk       = {1'b0, pos_reg} + k_reg;
    assign a_out     = (apk > n12);
    assign same      = (cur1_reg == prev1_reg)
                       && (a_out ? prevout_reg : (!prevout_reg && sk_q == prev2_reg));
    assign pnew      = (idx_reg == 12'd1) ? 12'd1 : (same ? p_reg : p_reg + 12'd1);
    assign ih        = idx_reg + {1'b0, h_reg};
    assign jh        = {1'b0, j_reg} + {1'b0, h_reg};
    assign scan_ok   = (ih <= n12) && (jh <= n12);
    assign span      = 12'd1 << lvl_reg;
    assign half      = span >> 1;
    assign q_min     = (key_reg < rk_q) ? key_reg : rk_q;
    assign q_max     = (key_reg < rk_q) ? rk_q : key_reg;
    assign qlen      = q_max - q_min;
    assign qlvl      = floor_lvl(qlen);
    assign qd_pos    = {1'b0, r_reg} - span + 12'd1;
    assign pa_bad    = (position_a == '0) || (position_a > len_reg);
    assign pb_bad    = (position_b == '0) || (position_b > len_reg);

    always_comb
    begin
        sym_we = 1'b0; sym_waddr = '0; sym_wdata = '0; sym_raddr = '0;
        sa_we  = 1'b0; sa_waddr  = '0; sa_wdata  = '0; sa_raddr  = position_a[PosAw-1:0];
        rk_we  = 1'b0; rk_waddr  = '0; rk_wdata  = '0; rk_raddr  = '0;
        sk_we  = 1'b0; sk_waddr  = '0; sk_wdata  = '0; sk_raddr  = '0;
        ht_we  = 1'b0; ht_waddr  = '0; ht_wdata  = '0; ht_raddr  = position_a[PosAw-1:0];
        cnt_we = 1'b0; cnt_waddr = '0; cnt_wdata = '0; cnt_raddr = '0;
        mt_we  = 1'b0; mt_waddr  = '0; mt_wdata  = '0; mt_raddr  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && mode == MODE_LOAD && load_room)
                begin
                    sym_we    = 1'b1;
                    sym_waddr = new_len[PosAw-1:0];
                    sym_wdata = symbol;
                end
            end
            S_B0_RD: sym_raddr = idx_a;
            S_B0_WR:
            begin
                rk_we = 1'b1; rk_waddr = idx_a; rk_wdata = sym_q;
                sk_we = 1'b1; sk_waddr = idx_a; sk_wdata = idx_reg[Dw-1:0];
            end
            S_C1:
            begin
                cnt_we = 1'b1; cnt_waddr = idx_reg[CntAw-1:0];
            end
            S_C2_A: rk_raddr = idx_a;
            S_C2_B: cnt_raddr = rk_q;
            S_C2_C:
            begin
                cnt_we = 1'b1; cnt_waddr = key_reg; cnt_wdata = cnt_q + 1'b1;
            end
            S_C3_A: cnt_raddr = idx_reg[CntAw-1:0];
            S_C3_B:
            begin
                cnt_we = 1'b1; cnt_waddr = idx_reg[CntAw-1:0]; cnt_wdata = run_reg + cnt_q;
            end
            S_C4_A: sk_raddr = idx_a;
            S_C4_B: rk_raddr = sk_q[PosAw-1:0];
            S_C4_C: cnt_raddr = rk_q;
            S_C4_D:
            begin
                cnt_we = 1'b1; cnt_waddr = key_reg; cnt_wdata = cnt_q - 1'b1;
                sa_we  = 1'b1; sa_waddr = cnt_q[PosAw-1:0]; sa_wdata = pos_reg;
            end
            S_D1:
            begin
                sk_we = 1'b1; sk_waddr = idx_a;
                sk_wdata = len_reg - idx_reg[Dw-1:0] + 1'b1;
            end
            S_D2_A: sa_raddr = idx_a;
            S_D2_B:
            begin
                if ({1'b0, sa_q} > k_reg)
                begin
                    sk_we = 1'b1;
                    sk_waddr = PosAw'(p_reg + 12'd1);
                    sk_wdata = sa_q - k_reg[Dw-1:0];
                end
            end
            S_D3_A:
            begin
                rk_raddr = idx_a; sk_raddr = idx_a;
            end
            S_D3_B:
            begin
                rk_we = 1'b1; rk_waddr = idx_a; rk_wdata = sk_q;
                sk_we = 1'b1; sk_waddr = idx_a; sk_wdata = rk_q;
            end
            S_E0: sa_raddr = idx_a;
            S_E1: sk_raddr = sa_q[PosAw-1:0];
            S_E2: sk_raddr = apk[PosAw-1:0];
            S_E3:
            begin
                rk_we = 1'b1; rk_waddr = pos_reg[PosAw-1:0]; rk_wdata = pnew[Dw-1:0];
            end
            S_F_A: sa_raddr = idx_a;
            S_F_B:
            begin
                rk_we = 1'b1; rk_waddr = sa_q[PosAw-1:0]; rk_wdata = idx_reg[Dw-1:0];
            end
            S_K0: rk_raddr = idx_a;
            S_K1:
            begin
                if (rk_q > Dw'(1))
                begin
                    sa_raddr = PosAw'(rk_q - 1'b1);
                end
                else
                begin
                    ht_we = 1'b1; ht_waddr = PosAw'(1);
                end
            end
            S_K2: ;
            S_K3:
            begin
                if (scan_ok)
                begin
                    sym_raddr = ih[PosAw-1:0];
                end
                else
                begin
                    ht_we = 1'b1; ht_waddr = r_reg[PosAw-1:0]; ht_wdata = h_reg;
                end
            end
            S_K4: sym_raddr = jh[PosAw-1:0];
            S_K5:
            begin
                if (sym_q != syma_reg)
                begin
                    ht_we = 1'b1; ht_waddr = r_reg[PosAw-1:0]; ht_wdata = h_reg;
                end
            end
            S_L0_A: ht_raddr = idx_a;
            S_L0_B:
            begin
                mt_we = 1'b1; mt_waddr = {LvlW'(0), idx_a}; mt_wdata = ht_q;
            end
            S_M_CHK: ;
            S_M0: mt_raddr = {lvl_reg - 1'b1, idx_a};
            S_M1:
            begin
                mt_raddr = {lvl_reg - 1'b1, PosAw'(idx_reg + half)};
            end
            S_M2:
            begin
                mt_we = 1'b1; mt_waddr = {lvl_reg, idx_a};
                mt_wdata = (minv_reg < mt_q) ? minv_reg : mt_q;
            end
            S_QR: ;
            S_QA: rk_raddr = qa_reg[PosAw-1:0];
            S_QB: rk_raddr = qb_reg[PosAw-1:0];
            S_QC: mt_raddr = {qlvl, PosAw'(q_min + 1'b1)};
            S_QD: mt_raddr = {lvl_reg, qd_pos[PosAw-1:0]};
            S_QE: ;
            S_OUT: ;
            default: ;
        endcase
    end

    sal_ram #(.Width(Dw), .Depth(MaxLen)) u_sym (
        .clk(clk), .we(sym_we), .waddr(sym_waddr), .wdata(sym_wdata),
        .raddr(sym_raddr), .rdata(sym_q)
    );
    sal_ram #(.Width(Dw), .Depth(MaxLen)) u_sa (
        .clk(clk), .we(sa_we), .waddr(sa_waddr), .wdata(sa_wdata),
        .raddr(sa_raddr), .rdata(sa_q)
    );
    sal_ram #(.Width(Dw), .Depth(MaxLen)) u_rk (
        .clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
        .raddr(rk_raddr), .rdata(rk_q)
    );
    sal_ram #(.Width(Dw), .Depth(MaxLen)) u_sk (
        .clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
        .raddr(sk_raddr), .rdata(sk_q)
    );
    sal_ram #(.Width(Dw), .Depth(MaxLen)) u_ht (
        .clk(clk), .we(ht_we), .waddr(ht_waddr), .wdata(ht_wdata),
        .raddr(ht_raddr), .rdata(ht_q)
    );
    sal_ram #(.Width(Dw), .Depth(CntDepth)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_q)
    );
    sal_ram #(.Width(Dw), .Depth(MtDepth)) u_mt (
        .clk(clk), .we(mt_we), .waddr(mt_waddr), .wdata(mt_wdata),
        .raddr(mt_raddr), .rdata(mt_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            len_reg        <= '0;
            built_reg      <= 1'b0;
            idx_reg        <= '0;
            p_reg          <= '0;
            k_reg          <= 12'd1;
            keymax_reg     <= '0;
            run_reg        <= '0;
            key_reg        <= '0;
            pos_reg        <= '0;
            prev1_reg      <= '0;
            prev2_reg      <= '0;
            prevout_reg    <= 1'b0;
            cur1_reg       <= '0;
            h_reg          <= '0;
            r_reg          <= '0;
            j_reg          <= '0;
            syma_reg       <= '0;
            minv_reg       <= '0;
            lvl_reg        <= '0;
            first_sort_reg <= 1'b0;
            qa_reg         <= '0;
            qb_reg         <= '0;
            res_start_reg  <= '0;
            res_height_reg <= '0;
            res_common_reg <= '0;
            res_oor_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            start_reg      <= '0;
            height_reg     <= '0;
            common_reg     <= '0;
            oor_reg        <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_start_reg  <= '0;
                        res_height_reg <= '0;
                        res_common_reg <= '0;
                        res_oor_reg    <= 1'b0;
                        unique case (mode_t'(mode))
                            MODE_LOAD:
                            begin
                                built_reg <= 1'b0;
                                len_reg   <= new_len;
                                if (last_symbol)
                                begin
                                    built_reg <= 1'b1;
                                    idx_reg   <= 12'd1;
                                    if (new_len != '0)
                                    begin
                                        state_reg <= S_B0_RD;
                                    end
                                end
                            end
                            MODE_RANK:
                            begin
                                if (!built_reg)
                                begin
                                    state_reg <= S_OUT;
                                end
                                else if (pa_bad)
                                begin
                                    res_oor_reg <= 1'b1;
                                    state_reg   <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_QR;
                                end
                            end
                            MODE_LCP:
                            begin
                                qa_reg <= position_a;
                                qb_reg <= position_b;
                                if (!built_reg)
                                begin
                                    state_reg <= S_OUT;
                                end
                                else if (pa_bad || pb_bad)
                                begin
                                    res_oor_reg <= 1'b1;
                                    state_reg   <= S_OUT;
                                end
                                else if (position_a == position_b)
                                begin
                                    res_common_reg <= len_reg - position_a + 1'b1;
                                    state_reg      <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_QA;
                                end
                            end
                            MODE_NONE: ;
                            default: ;
                        endcase
                    end
                end
                S_B0_RD: state_reg <= S_B0_WR;
                S_B0_WR:
                begin
                    if (idx_reg == n12)
                    begin
                        first_sort_reg <= 1'b1;
                        keymax_reg     <= '1;
                        idx_reg        <= '0;
                        state_reg      <= S_C1;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 12'd1;
                        state_reg <= S_B0_RD;
                    end
                end
                S_C1:
                begin
                    if (idx_reg[Dw-1:0] == keymax_reg)
                    begin
                        idx_reg   <= 12'd1;
                        state_reg <= S_C2_A;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 12'd1;
                    end
                end
                S_C2_A: state_reg <= S_C2_B;
                S_C2_B:
                begin
                    key_reg   <= rk_q;
                    state_reg <= S_C2_C;
                end
                S_C2_C:
                begin
                    if (idx_reg == n12)
                    begin
                        idx_reg   <= '0;
                        run_reg   <= '0;
                        state_reg <= S_C3_A;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 12'd1;
                        state_reg <= S_C2_A;
                    end
                end
                S_C3_A: state_reg <= S_C3_B;
                S_C3_B:
                begin
                    run_reg <= run_reg + cnt_q;
                    if (idx_reg[Dw-1:0] == keymax_reg)
                    begin
                        idx_reg   <= n12;
                        state_reg <= S_C4_A;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 12'd1;
                        state_reg <= S_C3_A;
                    end
                end
                S_C4_A: state_reg <= S_C4_B;
                S_C4_B:
                begin
                    pos_reg   <= sk_q;
                    state_reg <= S_C4_C;
                end
                S_C4_C:
                begin
                    key_reg   <= rk_q;
                    state_reg <= S_C4_D;
                end
                S_C4_D:
                begin
                    if (idx_reg == 12'd1)
                    begin
                        idx_reg <= 12'd1;
                        if (first_sort_reg)
                        begin
                            k_reg     <= 12'd1;
                            state_reg <= S_D1;
                        end
                        else
                        begin
                            state_reg <= S_D3_A;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - 12'd1;
                        state_reg <= S_C4_A;
                    end
                end
                S_D1:
                begin
                    if (idx_reg == k_reg)
                    begin
                        p_reg     <= k_reg;
                        idx_reg   <= 12'd1;
                        state_reg <= S_D2_A;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 12'd1;
                    end
                end
                S_D2_A: state_reg <= S_D2_B;
                S_D2_B:
                begin
                    if ({1'b0, sa_q} > k_reg)
                    begin
                        p_reg <= p_reg + 12'd1;
                    end
                    if (idx_reg == n12)
                    begin
                        first_sort_reg <= 1'b0;
                        idx_reg        <= '0;
                        state_reg      <= S_C1;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 12'd1;
                        state_reg <= S_D2_A;
                    end
                end
                S_D3_A: state_reg <= S_D3_B;
                S_D3_B:
                begin
                    if (idx_reg == n12)
                    begin
                        idx_reg   <= 12'd1;
                        state_reg <= S_E0;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 12'd1;
                        state_reg <= S_D3_A;
                    end
                end
                S_E0: state_reg <= S_E1;
                S_E1:
                begin
                    pos_reg   <= sa_q;
                    state_reg <= S_E2;
                end
                S_E2:
                begin
                    cur1_reg  <= sk_q;
                    state_reg <= S_E3;
                end
                S_E3:
                begin
                    p_reg       <= pnew;
                    prev1_reg   <= cur1_reg;
                    prev2_reg   <= sk_q;
                    prevout_reg <= a_out;
                    if (idx_reg == n12)
                    begin
                        keymax_reg <= pnew[Dw-1:0];
                        k_reg      <= k_reg << 1;
                        idx_reg    <= 12'd1;
                        state_reg  <= ((k_reg << 1) <= n12) ? S_D1 : S_F_A;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 12'd1;
                        state_reg <= S_E0;
                    end
                end
                S_F_A: state_reg <= S_F_B;
                S_F_B:
                begin
                    if (idx_reg == n12)
                    begin
                        idx_reg   <= 12'd1;
                        h_reg     <= '0;
                        state_reg <= S_K0;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 12'd1;
                        state_reg <= S_F_A;
                    end
                end
                S_K0:
                begin
                    if (h_reg != '0)
                    begin
                        h_reg <= h_reg - 1'b1;
                    end
                    state_reg <= S_K1;
                end
                S_K1:
                begin
                    r_reg <= rk_q;
                    if (rk_q <= Dw'(1))
                    begin
                        h_reg <= '0;
                        if (idx_reg == n12)
                        begin
                            idx_reg   <= 12'd1;
                            state_reg <= S_L0_A;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 12'd1;
                            state_reg <= S_K0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_K2;
                    end
                end
                S_K2:
                begin
                    j_reg     <= sa_q;
                    state_reg <= S_K3;
                end
                S_K3:
                begin
                    if (scan_ok)
                    begin
                        state_reg <= S_K4;
                    end
                    else if (idx_reg == n12)
                    begin
                        idx_reg   <= 12'd1;
                        state_reg <= S_L0_A;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 12'd1;
                        state_reg <= S_K0;
                    end
                end
                S_K4:
                begin
                    syma_reg  <= sym_q;
                    state_reg <= S_K5;
                end
                S_K5:
                begin
                    if (sym_q == syma_reg)
                    begin
                        h_reg     <= h_reg + 1'b1;
                        state_reg <= S_K3;
                    end
                    else if (idx_reg == n12)
                    begin
                        idx_reg   <= 12'd1;
                        state_reg <= S_L0_A;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 12'd1;
                        state_reg <= S_K0;
                    end
                end
                S_L0_A: state_reg <= S_L0_B;
                S_L0_B:
                begin
                    if (idx_reg == n12)
                    begin
                        idx_reg   <= 12'd1;
                        lvl_reg   <= LvlW'(1);
                        state_reg <= S_M_CHK;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 12'd1;
                        state_reg <= S_L0_A;
                    end
                end
                S_M_CHK:
                begin
                    if (lvl_reg == LvlW'(LogLevels))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (idx_reg + span <= n12 + 12'd1)
                    begin
                        state_reg <= S_M0;
                    end
                    else
                    begin
                        lvl_reg <= lvl_reg + 1'b1;
                        idx_reg <= 12'd1;
                    end
                end
                S_M0: state_reg <= S_M1;
                S_M1:
                begin
                    minv_reg  <= mt_q;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    idx_reg   <= idx_reg + 12'd1;
                    state_reg <= S_M_CHK;
                end
                S_QR:
                begin
                    res_start_reg  <= sa_q;
                    res_height_reg <= ht_q;
                    state_reg      <= S_OUT;
                end
                S_QA: state_reg <= S_QB;
                S_QB:
                begin
                    key_reg   <= rk_q;
                    state_reg <= S_QC;
                end
                S_QC:
                begin
                    lvl_reg   <= qlvl;
                    r_reg     <= q_max;
                    state_reg <= S_QD;
                end
                S_QD:
                begin
                    minv_reg  <= mt_q;
                    state_reg <= S_QE;
                end
                S_QE:
                begin
                    res_common_reg <= (minv_reg < mt_q) ? minv_reg : mt_q;
                    state_reg      <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        start_reg     <= res_start_reg;
                        height_reg    <= res_height_reg;
                        common_reg    <= res_common_reg;
                        oor_reg       <= res_oor_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign suffix_start  = start_reg;
    assign height        = height_reg;
    assign common_length = common_reg;
    assign out_of_range  = oor_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= Dw'(MaxLen))
        else $error("loaded length beyond capacity");

    a_k_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(k_reg))
        else $error("doubling step not a power of two");

    a_build_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_E3 || state_reg == S_K3 || state_reg == S_M2) |-> built_reg)
        else $error("build running without built flag");

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_E3) |-> (pnew <= n12))
        else $error("class rank exceeds length");

endmodule
